// ----- hdl/kts_pkg.sv -----
// shared types and constants of the topological sort block
`default_nettype none
package kts_pkg;

    localparam int FIELD_W = 6;
    localparam int NCW = 7;
    localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_RUN = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t              op;
        logic [FIELD_W-1:0] edge_from;
        logic [FIELD_W-1:0] edge_to;
    } item_t;

    typedef struct packed
    {
        logic [FIELD_W-1:0] node_index;
        logic             node_valid;
        logic             is_last;
        logic             acyclic;
        logic             edges_dropped;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/kts_if.sv -----
// request and result channel interfaces
`default_nettype none
interface kts_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [5:0] edge_from;
    logic [5:0] edge_to;

    modport source (output valid, output req_type, output edge_from, output edge_to,
                    input ready);
    modport sink (input valid, input req_type, input edge_from, input edge_to,
                  output ready);
endinterface

interface kts_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] node_index;
    logic       node_valid;
    logic       is_last;
    logic       acyclic;
    logic       edges_dropped;

    modport source (output valid, output node_index, output node_valid, output is_last,
                    output acyclic, output edges_dropped, input ready);
    modport sink (input valid, input node_index, input node_valid, input is_last,
                  input acyclic, input edges_dropped, output ready);
endinterface
`default_nettype wire

// ----- hdl/kts_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/kts_front.sv -----
// front end: takes request transfers, classifies them and queues them for the back end
`default_nettype none
module kts_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    kts_req_if.sink            req,
    output logic               q_valid,
    output kts_pkg::item_t     q_item,
    input  wire logic          q_take
);

    kts_pkg::item_t slot_reg [2];
    logic [1:0] fill_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    kts_pkg::item_t item_in;

    // classify the incoming request
    always_comb
    begin
        item_in.op        = req.req_type ? kts_pkg::OP_RUN : kts_pkg::OP_ADD;
        item_in.edge_from = req.edge_from;
        item_in.edge_to   = req.edge_to;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];

    // two entry queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_take};
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/kts_back.sv -----
// back end: edge store, in-degree count, ready queue walk and result register
`default_nettype none
module kts_back #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [kts_pkg::NCW-1:0] n_eff,
    input  wire logic                 q_valid,
    input  wire kts_pkg::item_t       q_item,
    output logic                      q_take,
    kts_rsp_if.source                 rsp
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int DW  = $clog2(MAX_EDGES + 1);
    localparam int NCW = kts_pkg::NCW;
    localparam int FW  = kts_pkg::FIELD_W;
    localparam logic [LW-1:0]  NULL_LINK = LW'(MAX_EDGES);
    localparam logic [NCW-1:0] QMAX      = NCW'(MAX_NODES);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_ADD2,
        S_CNT_NODE,
        S_CNT_HEAD,
        S_CNT_T,
        S_CNT_W,
        S_SEED,
        S_SEED_CHK,
        S_POP,
        S_PRC_X,
        S_PRC_HEAD,
        S_PRC_T,
        S_PRC_W,
        S_DONE_X,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic [MAX_NODES-1:0] head_valid_reg;
    logic [MAX_NODES-1:0] deg_valid_reg;
    logic [LW-1:0]  stored_reg;
    logic           drop_reg;
    logic [EW-1:0]  e_reg;
    logic [NW-1:0]  from_reg;
    logic [NW-1:0]  didx_reg;
    logic [NW-1:0]  x_reg;
    logic [LW-1:0]  link_reg;
    logic [NCW-1:0] u_reg;
    logic [NCW-1:0] qh_reg;
    logic [NCW-1:0] qt_reg;
    logic [NCW-1:0] cnt_reg;
    kts_pkg::result_t res_reg;
    kts_pkg::result_t out_reg;
    logic           out_valid_reg;

    // ram ports
    logic           tgt_we;
    logic [EW-1:0]  tgt_waddr;
    logic [FW-1:0]  tgt_wdata;
    logic [EW-1:0]  walk_raddr;
    logic [FW-1:0]  tgt_rdata;
    logic           link_we;
    logic [EW-1:0]  link_waddr;
    logic [LW-1:0]  link_wdata;
    logic [LW-1:0]  link_rdata;
    logic           head_we;
    logic [NW-1:0]  head_waddr;
    logic [NW-1:0]  head_raddr;
    logic [EW-1:0]  head_rdata;
    logic           tail_we;
    logic [NW-1:0]  tail_waddr;
    logic [EW-1:0]  tail_wdata;
    logic [EW-1:0]  tail_rdata;
    logic           deg_we;
    logic [DW-1:0]  deg_wdata;
    logic [NW-1:0]  deg_raddr;
    logic [DW-1:0]  deg_rdata;
    logic           rq_we;
    logic [NW-1:0]  rq_wdata;
    logic [NW-1:0]  rq_rdata;

    // helpers
    logic           is_add;
    logic           add_drop;
    logic           add_ok;
    logic [NW-1:0]  from_idx;
    logic [LW-1:0]  lk_cur;
    logic           lk_more;
    logic           t_in;
    logic [DW-1:0]  deg_cur;
    logic           out_free;

    assign q_take   = (state_reg == S_IDLE) && q_valid;
    assign is_add   = (q_item.op == kts_pkg::OP_ADD);
    assign from_idx = q_item.edge_from[NW-1:0];
    assign add_drop = ({1'b0, q_item.edge_from} >= n_eff) || ({1'b0, q_item.edge_to} >= n_eff)
                      || (stored_reg >= NULL_LINK);
    assign add_ok   = q_take && is_add && !add_drop;
    assign lk_cur   = ((state_reg == S_CNT_W) || (state_reg == S_PRC_W)) ? link_reg : link_rdata;
    assign lk_more  = (lk_cur < NULL_LINK);
    assign t_in     = ({1'b0, tgt_rdata} < n_eff);
    assign deg_cur  = deg_valid_reg[didx_reg] ? deg_rdata : '0;
    assign out_free = !out_valid_reg || rsp.ready;

    // ram address and write selection
    always_comb
    begin
        walk_raddr = ((state_reg == S_CNT_HEAD) || (state_reg == S_PRC_HEAD)) ?
                     head_rdata : lk_cur[EW-1:0];
        head_raddr = (state_reg == S_PRC_X) ? rq_rdata : u_reg[NW-1:0];
        deg_raddr  = (state_reg == S_SEED) ? u_reg[NW-1:0] : tgt_rdata[NW-1:0];

        tgt_we     = add_ok;
        tgt_waddr  = stored_reg[EW-1:0];
        tgt_wdata  = q_item.edge_to;

        link_we    = add_ok || (state_reg == S_ADD2);
        link_waddr = (state_reg == S_ADD2) ? tail_rdata : stored_reg[EW-1:0];
        link_wdata = (state_reg == S_ADD2) ? LW'(e_reg) : NULL_LINK;

        head_we    = add_ok && !head_valid_reg[from_idx];
        head_waddr = from_idx;

        tail_we    = (add_ok && !head_valid_reg[from_idx]) || (state_reg == S_ADD2);
        tail_waddr = (state_reg == S_ADD2) ? from_reg : from_idx;
        tail_wdata = (state_reg == S_ADD2) ? e_reg : stored_reg[EW-1:0];

        deg_we     = (state_reg == S_CNT_W) || ((state_reg == S_PRC_W) && (deg_cur != '0));
        deg_wdata  = (state_reg == S_CNT_W) ? deg_cur + DW'(1) : deg_cur - DW'(1);

        rq_we      = ((state_reg == S_SEED_CHK) && (deg_cur == '0))
                     || ((state_reg == S_PRC_W) && (deg_cur == DW'(1)) && (qt_reg < QMAX));
        rq_wdata   = (state_reg == S_SEED_CHK) ? u_reg[NW-1:0] : didx_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            deg_valid_reg  <= '0;
            stored_reg     <= '0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            u_reg          <= '0;
            qh_reg         <= '0;
            qt_reg         <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            if (deg_we)
            begin
                deg_valid_reg[didx_reg] <= 1'b1;
            end
            if (rq_we)
            begin
                qt_reg <= qt_reg + NCW'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        if (is_add)
                        begin
                            if (add_drop)
                            begin
                                drop_reg <= 1'b1;
                            end
                            else if (!head_valid_reg[from_idx])
                            begin
                                head_valid_reg[from_idx] <= 1'b1;
                                stored_reg <= stored_reg + LW'(1);
                            end
                            else
                            begin
                                e_reg     <= stored_reg[EW-1:0];
                                from_reg  <= from_idx;
                                state_reg <= S_ADD2;
                            end
                        end
                        else
                        begin
                            deg_valid_reg <= '0;
                            u_reg   <= '0;
                            qh_reg  <= '0;
                            qt_reg  <= '0;
                            cnt_reg <= '0;
                            state_reg <= S_CNT_NODE;
                        end
                    end
                end
                S_ADD2:
                begin
                    stored_reg <= stored_reg + LW'(1);
                    state_reg  <= S_IDLE;
                end
                // in-degree count over the stored edges whose source and target lie below the node count
                S_CNT_NODE:
                begin
                    if (u_reg == n_eff)
                    begin
                        u_reg     <= '0;
                        state_reg <= S_SEED;
                    end
                    else if (head_valid_reg[u_reg[NW-1:0]])
                    begin
                        state_reg <= S_CNT_HEAD;
                    end
                    else
                    begin
                        u_reg <= u_reg + NCW'(1);
                    end
                end
                S_CNT_HEAD:
                begin
                    state_reg <= S_CNT_T;
                end
                S_CNT_T:
                begin
                    if (t_in)
                    begin
                        didx_reg  <= tgt_rdata[NW-1:0];
                        link_reg  <= link_rdata;
                        state_reg <= S_CNT_W;
                    end
                    else if (!lk_more)
                    begin
                        u_reg     <= u_reg + NCW'(1);
                        state_reg <= S_CNT_NODE;
                    end
                end
                S_CNT_W:
                begin
                    if (lk_more)
                    begin
                        state_reg <= S_CNT_T;
                    end
                    else
                    begin
                        u_reg     <= u_reg + NCW'(1);
                        state_reg <= S_CNT_NODE;
                    end
                end
                // seed the ready queue in ascending order
                S_SEED:
                begin
                    if (u_reg == n_eff)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        didx_reg  <= u_reg[NW-1:0];
                        state_reg <= S_SEED_CHK;
                    end
                end
                S_SEED_CHK:
                begin
                    u_reg     <= u_reg + NCW'(1);
                    state_reg <= S_SEED;
                end
                // pop and relax successors
                S_POP:
                begin
                    if (qh_reg == qt_reg)
                    begin
                        res_reg.node_index    <= '0;
                        res_reg.node_valid    <= 1'b0;
                        res_reg.is_last       <= 1'b1;
                        res_reg.acyclic       <= (n_eff == '0);
                        res_reg.edges_dropped <= drop_reg;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        qh_reg    <= qh_reg + NCW'(1);
                        state_reg <= S_PRC_X;
                    end
                end
                S_PRC_X:
                begin
                    x_reg <= rq_rdata;
                    state_reg <= head_valid_reg[rq_rdata] ? S_PRC_HEAD : S_DONE_X;
                end
                S_PRC_HEAD:
                begin
                    state_reg <= S_PRC_T;
                end
                S_PRC_T:
                begin
                    if (t_in)
                    begin
                        didx_reg  <= tgt_rdata[NW-1:0];
                        link_reg  <= link_rdata;
                        state_reg <= S_PRC_W;
                    end
                    else if (!lk_more)
                    begin
                        state_reg <= S_DONE_X;
                    end
                end
                S_PRC_W:
                begin
                    state_reg <= lk_more ? S_PRC_T : S_DONE_X;
                end
                S_DONE_X:
                begin
                    res_reg.node_index    <= FW'(x_reg);
                    res_reg.node_valid    <= 1'b1;
                    res_reg.is_last       <= (qh_reg == qt_reg);
                    res_reg.acyclic       <= (qh_reg == qt_reg) && ((cnt_reg + NCW'(1)) == n_eff);
                    res_reg.edges_dropped <= drop_reg;
                    cnt_reg   <= cnt_reg + NCW'(1);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        if (res_reg.is_last)
                        begin
                            head_valid_reg <= '0;
                            deg_valid_reg  <= '0;
                            stored_reg     <= '0;
                            drop_reg       <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.node_index    = out_reg.node_index;
    assign rsp.node_valid    = out_reg.node_valid;
    assign rsp.is_last       = out_reg.is_last;
    assign rsp.acyclic       = out_reg.acyclic;
    assign rsp.edges_dropped = out_reg.edges_dropped;

    // memories
    kts_ram #(.WIDTH(FW), .DEPTH(MAX_EDGES)) u_tgt (
        .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .raddr(walk_raddr), .rdata(tgt_rdata));
    kts_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(walk_raddr), .rdata(link_rdata));
    kts_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(stored_reg[EW-1:0]),
        .raddr(head_raddr), .rdata(head_rdata));
    kts_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_tail (
        .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(from_idx), .rdata(tail_rdata));
    kts_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (
        .clk(clk), .we(deg_we), .waddr(didx_reg), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata));
    kts_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_rq (
        .clk(clk), .we(rq_we), .waddr(qt_reg[NW-1:0]), .wdata(rq_wdata),
        .raddr(qh_reg[NW-1:0]), .rdata(rq_rdata));

endmodule
`default_nettype wire

// ----- hdl/kahn_topological_sort.sv -----
// top level of the kahn topological sort block
//
//  channel | dir | transfer when     | payload
//  req     | in  | valid && ready    | req_type, edge_from, edge_to
//  rsp     | out | valid && ready    | node_index, node_valid, is_last, acyclic, edges_dropped
//  cfg     | in  | cfg_we            | node_count (7 bits)
//
// an add takes an extra back end state (S_ADD2) when the source already has edges
// a run counts in-degrees node by node and edge by edge, then seeds the ready queue,
// then pops each node and walks the edges on its list; one read port per ram
// reset clears the graph through valid bits at once; no clearing pass
// a two entry queue between front and back lets requests arrive while a run is busy,
// and a held result stalls only the back end
`default_nettype none
module kahn_topological_sort #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    kts_req_if.sink         req,
    kts_rsp_if.source       rsp
);

    localparam int NCW = kts_pkg::NCW;

    logic [NCW-1:0] node_count_reg;
    logic [NCW-1:0] n_eff;
    logic           q_valid;
    logic           q_take;
    kts_pkg::item_t q_item;

    // node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= kts_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    assign n_eff = (node_count_reg > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : node_count_reg;

    kts_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

    kts_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk(clk), .rst_n(rst_n), .n_eff(n_eff),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take), .rsp(rsp));

    // checks
    a_invalid_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.node_valid |-> rsp.is_last)
        else $error("invalid result before end of run");

    a_acyclic_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.acyclic |-> rsp.is_last)
        else $error("acyclic flag on a non-final result");

    a_full_offers: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> q_valid)
        else $error("queue full but nothing offered to back end");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("back end took from an empty queue");

endmodule
`default_nettype wire

// ----- sim/tb_kahn_topological_sort.sv -----
// self-checking testbench of the kahn topological sort block
`default_nettype none
module tb_kahn_topological_sort;

    localparam int MAXN = 64;
    localparam int MAXE = 256;
    localparam int TAIL_CYCLES = 4000;
    localparam int WATCHDOG_LIMIT = 200000;

    // scoreboard: graph shadow, sort prediction and result queue
    class sort_scoreboard;
        logic [5:0] dst_of[MAXE];
        int         succ[MAXN][$];
        int         n_edges;
        bit         dropped;
        int         node_limit;
        kts_pkg::result_t pending[$];
        int         mismatches;
        int         checked;
        int         runs;
        int         edges_kept;

        function void clear_graph();
            for (int i = 0; i < MAXN; i++)
                succ[i].delete();
            n_edges = 0;
            dropped = 0;
        endfunction

        function void set_nodes(int v);
            node_limit = (v > MAXN) ? MAXN : v;
        endfunction

        function void note_item(kts_pkg::item_t it);
            int   deg[MAXN];
            int   fifo[$];
            int   cnt;
            int   x;
            int   v;
            kts_pkg::result_t r;
            if (it.op == kts_pkg::OP_ADD)
            begin
                if (it.edge_from >= node_limit || it.edge_to >= node_limit
                    || n_edges >= MAXE)
                    dropped = 1;
                else
                begin
                    succ[it.edge_from] = {succ[it.edge_from], int'(it.edge_to)};
                    n_edges++;
                    edges_kept++;
                end
                return;
            end
            runs++;
            foreach (deg[i])
                deg[i] = 0;
            for (int u = 0; u < node_limit; u++)
                for (int k = 0; k < succ[u].size(); k++)
                    if (succ[u][k] < node_limit)
                        deg[succ[u][k]]++;
            for (int u = 0; u < node_limit; u++)
                if (deg[u] == 0)
                    fifo = {fifo, u};
            cnt = 0;
            while (fifo.size() > 0)
            begin
                x = fifo.pop_front();
                r = '0;
                r.node_index = x[5:0];
                r.node_valid = 1'b1;
                r.edges_dropped = dropped;
                pending = {pending, r};
                cnt++;
                for (int k = 0; k < succ[x].size(); k++)
                begin
                    v = succ[x][k];
                    if (v >= node_limit || deg[v] == 0)
                        continue;
                    deg[v]--;
                    if (deg[v] == 0)
                        fifo = {fifo, v};
                end
            end
            if (cnt == 0)
            begin
                r = '0;
                r.is_last = 1'b1;
                r.acyclic = (node_limit == 0);
                r.edges_dropped = dropped;
                pending = {pending, r};
            end
            else
            begin
                pending[pending.size() - 1].is_last = 1'b1;
                pending[pending.size() - 1].acyclic = (cnt == node_limit);
            end
            clear_graph();
        endfunction

        function void check_result(kts_pkg::result_t got);
            kts_pkg::result_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    kts_req_if  req_bus ();
    kts_rsp_if  rsp_bus ();

    sort_scoreboard sb;
    int  idle_cycles;
    int  rsp_wait;
    bit  stim_done;
    bit  lively;

    kahn_topological_sort u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus.sink),
        .rsp       (rsp_bus.source)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // drive one request and wait for its transfer; valid stays up for a following item
    task automatic send_item(input kts_pkg::item_t it);
        int gap;
        gap = lively ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= it.op;
        req_bus.edge_from <= it.edge_from;
        req_bus.edge_to <= it.edge_to;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic add_edge(input int a, input int b);
        kts_pkg::item_t it;
        it.op = kts_pkg::OP_ADD;
        it.edge_from = a[5:0];
        it.edge_to = b[5:0];
        send_item(it);
    endtask

    task automatic run_sort();
        kts_pkg::item_t it;
        it.op = kts_pkg::OP_RUN;
        it.edge_from = 6'($urandom);
        it.edge_to = 6'($urandom);
        send_item(it);
    endtask

    // wait for outstanding results, then let a trailing add settle
    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
    endtask

    task automatic write_nodes(input int v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[6:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_nodes(v);
    endtask

    // a random graph: mostly forward edges, some back edges and strays
    task automatic random_graph(input int nodes, input int edges);
        int a;
        int b;
        for (int i = 0; i < edges; i++)
        begin
            a = $urandom_range(0, nodes - 1);
            b = $urandom_range(0, nodes - 1);
            if ($urandom_range(0, 9) < 7 && a > b)
            begin
                int t;
                t = a;
                a = b;
                b = t;
            end
            if ($urandom_range(0, 19) == 0)
                b = $urandom_range(0, 63);
            add_edge(a, b);
        end
        run_sort();
    endtask

    // result sink
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            kts_pkg::result_t r;
            r.node_index = rsp_bus.node_index;
            r.node_valid = rsp_bus.node_valid;
            r.is_last = rsp_bus.is_last;
            r.acyclic = rsp_bus.acyclic;
            r.edges_dropped = rsp_bus.edges_dropped;
            sb.check_result(r);
        end
    end

    // ready, with a random wait before each result while lively is set
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_wait = lively ? $urandom_range(0, 3) : 0;
            if (rsp_wait != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (rsp_wait)
                    @(negedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!(rsp_bus.valid && rsp_bus.ready))
                @(posedge clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.clear_graph();
        sb.set_nodes(64);
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        lively = 1'b0;
        idle_cycles = 0;
        req_bus.valid = 1'b0;
        req_bus.req_type = 1'b0;
        req_bus.edge_from = '0;
        req_bus.edge_to = '0;
        rsp_bus.ready = 1'b1;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset count, extremes, cycle, self loop, drops
        add_edge(0, 63);
        add_edge(63, 0);
        add_edge(5, 5);
        add_edge(1, 2);
        add_edge(1, 3);
        add_edge(2, 3);
        run_sort();
        add_edge(0, 1);
        add_edge(1, 0);
        write_nodes(2);
        run_sort();
        add_edge(0, 1);
        add_edge(0, 2);
        add_edge(63, 1);
        run_sort();
        write_nodes(0);
        add_edge(0, 0);
        run_sort();
        write_nodes(127);
        add_edge(62, 63);
        add_edge(63, 62);
        run_sort();
        // count lowered after edges were stored
        add_edge(1, 40);
        add_edge(40, 0);
        write_nodes(4);
        run_sort();
        write_nodes(1);
        run_sort();

        // store full: more edges than the store holds
        write_nodes(8);
        for (int i = 0; i < MAXE + 4; i++)
            add_edge($urandom_range(0, 7), $urandom_range(0, 7));
        run_sort();

        // random phase
        lively = 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            int nodes;
            case (ph)
                0: nodes = 64;
                1: nodes = 3;
                2: nodes = 16;
                3: nodes = 65;
                default: nodes = $urandom_range(1, 64);
            endcase
            write_nodes(nodes);
            for (int g = 0; g < 3; g++)
            begin
                int m;
                m = (nodes > 64) ? 64 : nodes;
                random_graph(m, $urandom_range(0, 6));
                if (g == 1)
                    drain();
            end
        end
        // bit toggling on every field
        write_nodes(64);
        for (int i = 0; i < 12; i++)
            add_edge($urandom_range(0, 63), $urandom_range(0, 63));
        run_sort();

        stim_done = 1'b1;
        req_bus.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES)
            @(negedge clk);
        $display("covered %0d sorts, %0d stored edges, %0d results checked",
                 sb.runs, sb.edges_kept, sb.checked);
        $display("node counts from 0 to 127 with drops, cycles and stalls on both sides");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/kts_pkg.sv
hdl/kts_if.sv
hdl/kts_ram.sv
hdl/kts_front.sv
hdl/kts_back.sv
hdl/kahn_topological_sort.sv
sim/tb_kahn_topological_sort.sv
